@@ design/etpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape-time palette colour map: shared definitions
// Register indexes, datapath widths, the request record that travels down the
// divide row, and the two palette ROMs.
// ----------------------------------------------------------------------------
package etpc_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_PALETTE_MODE      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTRE_WHITE      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_ITERATIONS    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_COLOUR_MULTIPLIER = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_COLOUR_OFFSET     = 3'd4;

    localparam logic [1:0] MODE_GREY    = 2'd0;
    localparam logic [1:0] MODE_RAINBOW = 2'd1;

    localparam logic [1:0]  RST_PALETTE_MODE      = 2'd0;
    localparam logic        RST_CENTRE_WHITE      = 1'b0;
    localparam logic [15:0] RST_MAX_ITERATIONS    = 16'd256;
    localparam logic [15:0] RST_COLOUR_MULTIPLIER = 16'd256;
    localparam logic [15:0] RST_COLOUR_OFFSET     = 16'd0;

    localparam int IN_W    = 32;
    localparam int PROD_W  = 48;
    localparam int FRAC_W  = 24;
    localparam int DIV_W   = 40;
    localparam int QUO_W   = 9;
    localparam int NCELLS  = 9;
    localparam int DIV_BASE_SHIFT = 16;
    localparam int IDX_W   = 25;

    // Multiple of both 7 and 16 that makes every palette index non-negative.
    localparam logic [IDX_W:0] IDX_BIAS = 26'd14680064;

    localparam logic [23:0] WHITE = 24'hFFFFFF;
    localparam logic [7:0]  LEVEL_MAX = 8'd255;

    typedef struct packed {
        logic              pos;
        logic              in_set;
        logic [PROD_W-1:0] prod;
        logic [DIV_W-1:0]  rem;
        logic [QUO_W-1:0]  quo;
    } div_item_t;

    function automatic logic [23:0] rainbow_rom(input logic [2:0] idx);
        logic [23:0] c;
        unique case (idx)
            3'd0:    c = 24'he81416;
            3'd1:    c = 24'hffa500;
            3'd2:    c = 24'hfaeb36;
            3'd3:    c = 24'h79c314;
            3'd4:    c = 24'h487de7;
            3'd5:    c = 24'h4b369d;
            3'd6:    c = 24'h70369d;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

    function automatic logic [23:0] bbw_rom(input logic [3:0] idx);
        logic [23:0] c;
        unique case (idx)
            4'd0:    c = 24'h0d0033;
            4'd1:    c = 24'h000043;
            4'd2:    c = 24'h062869;
            4'd3:    c = 24'h042596;
            4'd4:    c = 24'h1e56a7;
            4'd5:    c = 24'h2daac7;
            4'd6:    c = 24'h89c8f5;
            4'd7:    c = 24'hd6fbff;
            4'd8:    c = 24'hded8ae;
            4'd9:    c = 24'hffcb5a;
            4'd10:   c = 24'hf5af17;
            4'd11:   c = 24'hded8ac;
            4'd12:   c = 24'h935600;
            4'd13:   c = 24'h6f3608;
            4'd14:   c = 24'h3d1e11;
            4'd15:   c = 24'h1b081a;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

endpackage

@@ design/etpc_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divide cell
// One restoring step of the grey-level division: compares the remainder with
// the shifted divisor, subtracts on success and shifts in one quotient bit.
// ----------------------------------------------------------------------------
module etpc_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [15:0]          max_iterations,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  etpc_pkg::div_item_t  in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output etpc_pkg::div_item_t  out_item
);

    localparam int W = etpc_pkg::DIV_W;
    localparam int Q = etpc_pkg::QUO_W;

    logic                valid_reg;
    etpc_pkg::div_item_t item_reg;
    etpc_pkg::div_item_t item_next;
    logic [W-1:0]        dsh;
    logic                ge;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        dsh       = W'(max_iterations) << (etpc_pkg::DIV_BASE_SHIFT + SHIFT);
        ge        = in_item.rem >= dsh;
        item_next = in_item;
        if (ge) begin
            item_next.rem = in_item.rem - dsh;
        end
        item_next.quo = {in_item.quo[Q-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

@@ design/etpc_palette.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette back end
// Forms the wrapped palette index, reads both ROM entries, interpolates each
// channel and selects the final colour in a six-stage pipeline.
// ----------------------------------------------------------------------------
module etpc_palette (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [1:0]          palette_mode,
    input  logic                centre_white,
    input  logic [15:0]         colour_offset,
    input  logic                in_valid,
    output logic                in_ready,
    input  etpc_pkg::div_item_t in_item,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [23:0]         m_rgb_colour
);

    localparam int NST = 6;
    localparam int FW  = etpc_pkg::FRAC_W;
    localparam int PW  = etpc_pkg::PROD_W;
    localparam int IW  = etpc_pkg::IDX_W;

    logic [NST-1:0] v_reg;
    logic [NST:0]   rdy;

    logic [IW-1:0]  s1_u_reg;
    logic [FW-1:0]  s1_t_reg;
    logic [7:0]     s1_lvl_reg;
    logic           s1_inside_reg;

    logic [5:0]     s2_sum_reg;
    logic [3:0]     s2_i16_reg;
    logic [FW-1:0]  s2_t_reg;
    logic [7:0]     s2_lvl_reg;
    logic           s2_inside_reg;

    logic [3:0]     s3_i0_reg;
    logic [3:0]     s3_i1_reg;
    logic [FW-1:0]  s3_t_reg;
    logic [7:0]     s3_lvl_reg;
    logic           s3_inside_reg;

    logic [23:0]    s4_c0_reg;
    logic [23:0]    s4_c1_reg;
    logic [FW-1:0]  s4_t_reg;
    logic [7:0]     s4_lvl_reg;
    logic           s4_inside_reg;

    logic [23:0]        s5_a_reg;
    logic signed [33:0] s5_prod_reg [3];
    logic [7:0]         s5_lvl_reg;
    logic               s5_inside_reg;

    logic [23:0]    rgb_reg;

    logic [7:0]         lvl;
    logic signed [IW-1:0] idx;
    logic [IW:0]        u_full;
    logic [5:0]         sum;
    logic [3:0]         fold;
    logic [2:0]         r7;
    logic [3:0]         i0;
    logic [3:0]         i1;
    logic [23:0]        c0;
    logic [23:0]        c1;
    logic signed [33:0] prod_next [3];
    logic [23:0]        lerp;
    logic [23:0]        rgb_next;

    assign rdy[NST] = m_ready;
    for (genvar k = 0; k < NST; k++) begin : g_rdy
        assign rdy[k] = !v_reg[k] || rdy[k+1];
    end

    assign in_ready     = rdy[0];
    assign m_valid      = v_reg[NST-1];
    assign m_rgb_colour = rgb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_comb begin
        if (!in_item.pos) begin
            lvl = '0;
        end else if (in_item.quo[etpc_pkg::QUO_W-1]) begin
            lvl = etpc_pkg::LEVEL_MAX;
        end else begin
            lvl = in_item.quo[7:0];
        end
        idx = IW'($signed(in_item.prod[PW-1:FW])) + IW'($signed(colour_offset));
        u_full = $unsigned($signed({idx[IW-1], idx}) + $signed(etpc_pkg::IDX_BIAS));
    end

    // Eight is one more than seven, so the octal digits keep the value mod 7.
    always_comb begin
        sum = 6'(s1_u_reg[IW-1]);
        for (int i = 0; i < 8; i++) begin
            sum = sum + 6'(s1_u_reg[3*i +: 3]);
        end
    end

    always_comb begin
        fold = 4'(s2_sum_reg[5:3]) + 4'(s2_sum_reg[2:0]);
        if (fold >= 4'd14) begin
            r7 = 3'(fold - 4'd14);
        end else if (fold >= 4'd7) begin
            r7 = 3'(fold - 4'd7);
        end else begin
            r7 = fold[2:0];
        end
        if (palette_mode[1]) begin
            i0 = s2_i16_reg;
            i1 = s2_i16_reg + 4'd1;
        end else begin
            i0 = {1'b0, r7};
            i1 = (r7 == 3'd6) ? 4'd0 : {1'b0, r7 + 3'd1};
        end
    end

    always_comb begin
        if (palette_mode[1]) begin
            c0 = etpc_pkg::bbw_rom(s3_i0_reg);
            c1 = etpc_pkg::bbw_rom(s3_i1_reg);
        end else begin
            c0 = etpc_pkg::rainbow_rom(s3_i0_reg[2:0]);
            c1 = etpc_pkg::rainbow_rom(s3_i1_reg[2:0]);
        end
    end

    always_comb begin
        logic signed [8:0] d;
        for (int ch = 0; ch < 3; ch++) begin
            d = $signed({1'b0, s4_c1_reg[8*ch +: 8]}) - $signed({1'b0, s4_c0_reg[8*ch +: 8]});
            prod_next[ch] = $signed({1'b0, s4_t_reg}) * d;
        end
    end

    always_comb begin
        logic [9:0] val;
        for (int ch = 0; ch < 3; ch++) begin
            val = {2'b00, s5_a_reg[8*ch +: 8]} + $unsigned(s5_prod_reg[ch][33:FW]);
            lerp[8*ch +: 8] = val[7:0];
        end
        if (s5_inside_reg) begin
            rgb_next = centre_white ? etpc_pkg::WHITE : '0;
        end else if (palette_mode == etpc_pkg::MODE_GREY) begin
            rgb_next = {s5_lvl_reg, s5_lvl_reg, s5_lvl_reg};
        end else begin
            rgb_next = lerp;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            s1_u_reg      <= u_full[IW-1:0];
            s1_t_reg      <= in_item.prod[FW-1:0];
            s1_lvl_reg    <= lvl;
            s1_inside_reg <= in_item.in_set;
        end
        if (rdy[1]) begin
            s2_sum_reg    <= sum;
            s2_i16_reg    <= s1_u_reg[3:0];
            s2_t_reg      <= s1_t_reg;
            s2_lvl_reg    <= s1_lvl_reg;
            s2_inside_reg <= s1_inside_reg;
        end
        if (rdy[2]) begin
            s3_i0_reg     <= i0;
            s3_i1_reg     <= i1;
            s3_t_reg      <= s2_t_reg;
            s3_lvl_reg    <= s2_lvl_reg;
            s3_inside_reg <= s2_inside_reg;
        end
        if (rdy[3]) begin
            s4_c0_reg     <= c0;
            s4_c1_reg     <= c1;
            s4_t_reg      <= s3_t_reg;
            s4_lvl_reg    <= s3_lvl_reg;
            s4_inside_reg <= s3_inside_reg;
        end
        if (rdy[4]) begin
            s5_a_reg      <= s4_c0_reg;
            s5_prod_reg   <= prod_next;
            s5_lvl_reg    <= s4_lvl_reg;
            s5_inside_reg <= s4_inside_reg;
        end
        if (rdy[5]) begin
            rgb_reg <= rgb_next;
        end
    end

endmodule

@@ design/escape_time_palette_colour_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape-time palette colour map
// Turns one escape-time result per pixel into a 24-bit RGB colour, either a
// grey level, an interpolated palette colour, or black or white inside the set.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the output is not stalled. Each
// request passes 16 register stages: one for the input multiply, nine for the
// row of divide cells that forms the grey level one quotient bit per cell, and
// six for the palette index, ROM read, interpolation and output register. A
// stalled output holds the pipeline back stage by stage, so bubbles are
// squeezed out before the input side is stopped.
module escape_time_palette_colour_map (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_inside_set,
    input  logic signed [31:0]                 s_smooth_iters,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [23:0]                        m_rgb_colour,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [etpc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [etpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int NC = etpc_pkg::NCELLS;
    localparam int DW = etpc_pkg::DIV_W;
    localparam int PW = etpc_pkg::PROD_W;

    logic [1:0]  palette_mode_reg;
    logic        centre_white_reg;
    logic [15:0] max_iterations_reg;
    logic [15:0] colour_multiplier_reg;
    logic [15:0] colour_offset_reg;

    logic                front_valid_reg;
    etpc_pkg::div_item_t front_item_reg;
    etpc_pkg::div_item_t front_next;
    logic signed [48:0]  prod_full;

    logic                link_valid [NC+1];
    logic                link_ready [NC+1];
    etpc_pkg::div_item_t link_item  [NC+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            palette_mode_reg      <= etpc_pkg::RST_PALETTE_MODE;
            centre_white_reg      <= etpc_pkg::RST_CENTRE_WHITE;
            max_iterations_reg    <= etpc_pkg::RST_MAX_ITERATIONS;
            colour_multiplier_reg <= etpc_pkg::RST_COLOUR_MULTIPLIER;
            colour_offset_reg     <= etpc_pkg::RST_COLOUR_OFFSET;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                etpc_pkg::REG_PALETTE_MODE:      palette_mode_reg      <= cfg_data[1:0];
                etpc_pkg::REG_CENTRE_WHITE:      centre_white_reg      <= cfg_data[0];
                etpc_pkg::REG_MAX_ITERATIONS:    max_iterations_reg    <= cfg_data;
                etpc_pkg::REG_COLOUR_MULTIPLIER: colour_multiplier_reg <= cfg_data;
                etpc_pkg::REG_COLOUR_OFFSET:     colour_offset_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_ready = !front_valid_reg || link_ready[0];

    always_comb begin
        prod_full         = s_smooth_iters * $signed({1'b0, colour_multiplier_reg});
        front_next.pos    = !s_smooth_iters[31] && (s_smooth_iters != '0);
        front_next.in_set = s_inside_set;
        front_next.prod   = prod_full[PW-1:0];
        front_next.quo    = '0;
        if (front_next.pos) begin
            front_next.rem = DW'({s_smooth_iters[30:0], 8'd0}) - DW'(s_smooth_iters[30:0]);
        end else begin
            front_next.rem = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (s_ready) begin
            front_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            front_item_reg <= front_next;
        end
    end

    assign link_valid[0] = front_valid_reg;
    assign link_item[0]  = front_item_reg;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        etpc_div_cell #(
            .SHIFT(NC - 1 - k)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .max_iterations (max_iterations_reg),
            .in_valid       (link_valid[k]),
            .in_ready       (link_ready[k]),
            .in_item        (link_item[k]),
            .out_valid      (link_valid[k+1]),
            .out_ready      (link_ready[k+1]),
            .out_item       (link_item[k+1])
        );
    end

    etpc_palette u_palette (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .palette_mode  (palette_mode_reg),
        .centre_white  (centre_white_reg),
        .colour_offset (colour_offset_reg),
        .in_valid      (link_valid[NC]),
        .in_ready      (link_ready[NC]),
        .in_item       (link_item[NC]),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rgb_colour  (m_rgb_colour)
    );

endmodule

@@ design/etpc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape-time palette colour map checker
// Port-level checks of reset, stall and flow-through behavior.
// ----------------------------------------------------------------------------
module etpc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [23:0] m_rgb_colour,
    input logic        cfg_ready
);

    // A stalled result must hold.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rgb_colour))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // With the sink ready, every stage can advance, so the input is free.
    a_flow_through: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output side is ready");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind escape_time_palette_colour_map etpc_checker u_etpc_checker (.*);

@@ tb/sv/tb_escape_time_palette_colour_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the escape-time palette colour map
// Pixel requests and register writes go in over their valid/ready channels,
// with random gaps on the input and random stalls on the output. A scoreboard
// keeps its own copy of the registers and palette tables, predicts every
// colour, and checks the colours in the order they come back.
// ----------------------------------------------------------------------------
module tb_escape_time_palette_colour_map;

    localparam int AW = etpc_pkg::CFG_ADDR_W;

    localparam logic [1:0] MODE_EARTH       = 2'd2;
    localparam logic [1:0] MODE_EARTH_ALIAS = 2'd3;

    localparam logic [AW-1:0] REG_UNUSED_FIRST = 3'd5;
    localparam logic [AW-1:0] REG_UNUSED_LAST  = 3'd7;

    localparam int    RAINBOW_SIZE     = 7;
    localparam int    EARTH_SIZE       = 16;
    localparam int    WEIGHT_BITS      = 24;
    localparam int    RANDOM_PHASES    = 10;
    localparam int    PIXELS_PER_PHASE = 125;
    localparam int    STEADY_PHASE     = 4;
    localparam int    IDLE_PERCENT     = 24;
    localparam int    INSIDE_PERCENT   = 15;
    localparam int    SETTLE_CYCLES    = 40;
    localparam longint RUN_LIMIT_NS    = 2_000_000;

    localparam logic [23:0] RAINBOW_TABLE [0:RAINBOW_SIZE-1] = '{
        24'he81416, 24'hffa500, 24'hfaeb36, 24'h79c314,
        24'h487de7, 24'h4b369d, 24'h70369d
    };

    localparam logic [23:0] EARTH_TABLE [0:EARTH_SIZE-1] = '{
        24'h0d0033, 24'h000043, 24'h062869, 24'h042596,
        24'h1e56a7, 24'h2daac7, 24'h89c8f5, 24'hd6fbff,
        24'hded8ae, 24'hffcb5a, 24'hf5af17, 24'hded8ac,
        24'h935600, 24'h6f3608, 24'h3d1e11, 24'h1b081a
    };

    class colour_scoreboard;
        logic [1:0]         palette_mode;
        logic               centre_white;
        logic [15:0]        max_iterations;
        logic [15:0]        colour_multiplier;
        logic signed [15:0] colour_offset;
        logic [23:0]        pending_colours[$];
        int unsigned        errors;

        function new();
            palette_mode      = etpc_pkg::RST_PALETTE_MODE;
            centre_white      = etpc_pkg::RST_CENTRE_WHITE;
            max_iterations    = etpc_pkg::RST_MAX_ITERATIONS;
            colour_multiplier = etpc_pkg::RST_COLOUR_MULTIPLIER;
            colour_offset     = etpc_pkg::RST_COLOUR_OFFSET;
            errors            = 0;
        endfunction

        function void set_register(logic [AW-1:0] idx, logic [15:0] data);
            case (idx)
                etpc_pkg::REG_PALETTE_MODE:      palette_mode = data[1:0];
                etpc_pkg::REG_CENTRE_WHITE:      centre_white = data[0];
                etpc_pkg::REG_MAX_ITERATIONS:    max_iterations = data;
                etpc_pkg::REG_COLOUR_MULTIPLIER: colour_multiplier = data;
                etpc_pkg::REG_COLOUR_OFFSET:     colour_offset = data;
                default: ;
            endcase
        endfunction

        function logic [23:0] grey_colour(logic signed [31:0] iters);
            longint     quotient;
            logic [7:0] level;
            if (iters <= 0) begin
                level = 8'd0;
            end else if (max_iterations == 16'd0) begin
                level = etpc_pkg::LEVEL_MAX;
            end else begin
                quotient = (longint'(iters) * longint'(etpc_pkg::LEVEL_MAX))
                           / (longint'(max_iterations) << 16);
                level = (quotient > longint'(etpc_pkg::LEVEL_MAX)) ? etpc_pkg::LEVEL_MAX
                                                                   : quotient[7:0];
            end
            return {level, level, level};
        endfunction

        function logic [7:0] blend(logic [7:0] start_level, logic [7:0] end_level,
                                   logic [23:0] weight);
            longint mix;
            mix = (longint'(start_level) << WEIGHT_BITS)
                  + longint'(weight) * (longint'(end_level) - longint'(start_level));
            return 8'(mix >>> WEIGHT_BITS);
        endfunction

        function logic [23:0] palette_colour(logic signed [31:0] iters);
            longint      product;
            longint      slot;
            longint      size;
            logic [23:0] weight;
            logic [23:0] first;
            logic [23:0] second;
            size = palette_mode[1] ? EARTH_SIZE : RAINBOW_SIZE;
            product = longint'(iters) * longint'(colour_multiplier);
            weight = product[23:0];
            slot = ((product >>> WEIGHT_BITS) + longint'(colour_offset)) % size;
            if (slot < 0) begin
                slot += size;
            end
            if (palette_mode[1]) begin
                first = EARTH_TABLE[slot];
                second = EARTH_TABLE[(slot + 1) % size];
            end else begin
                first = RAINBOW_TABLE[slot];
                second = RAINBOW_TABLE[(slot + 1) % size];
            end
            return {blend(first[23:16], second[23:16], weight),
                    blend(first[15:8], second[15:8], weight),
                    blend(first[7:0], second[7:0], weight)};
        endfunction

        function void note_request(logic in_set, logic signed [31:0] iters);
            logic [23:0] colour;
            if (in_set) begin
                colour = centre_white ? etpc_pkg::WHITE : 24'h000000;
            end else if (palette_mode == etpc_pkg::MODE_GREY) begin
                colour = grey_colour(iters);
            end else begin
                colour = palette_colour(iters);
            end
            pending_colours.push_back(colour);
        endfunction

        function void check_colour(logic [23:0] colour);
            logic [23:0] wanted;
            if (pending_colours.size() == 0) begin
                $display("%0t: colour %06h arrived with no request outstanding",
                         $time, colour);
                errors++;
            end else begin
                wanted = pending_colours.pop_front();
                if (colour !== wanted) begin
                    $display("%0t: colour mismatch: expected %06h, actual %06h",
                             $time, wanted, colour);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return pending_colours.size();
        endfunction
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic                            s_inside_set = 1'b0;
    logic signed [31:0]              s_smooth_iters = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [23:0]                     m_rgb_colour;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [AW-1:0]                   cfg_addr = '0;
    logic [etpc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    bit               steady = 1'b0;
    colour_scoreboard board;

    escape_time_palette_colour_map u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_inside_set   (s_inside_set),
        .s_smooth_iters (s_smooth_iters),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rgb_colour   (m_rgb_colour),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99, 0) >= IDLE_PERCENT);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_colour(m_rgb_colour);
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic write_reg(input logic [AW-1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.set_register(idx, data);
    endtask

    // Writes every register; the block must be idle when this is called.
    task automatic configure(input logic [1:0] mode, input logic white,
                             input logic [15:0] max_iter, input logic [15:0] mult,
                             input logic [15:0] offset);
        write_reg(3'($urandom_range(int'(REG_UNUSED_LAST), int'(REG_UNUSED_FIRST))),
                  16'($urandom));
        write_reg(etpc_pkg::REG_PALETTE_MODE, {14'd0, mode});
        write_reg(etpc_pkg::REG_CENTRE_WHITE, {15'd0, white});
        write_reg(etpc_pkg::REG_MAX_ITERATIONS, max_iter);
        write_reg(etpc_pkg::REG_COLOUR_MULTIPLIER, mult);
        write_reg(etpc_pkg::REG_COLOUR_OFFSET, offset);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input logic in_set, input logic [31:0] iters);
        while (!steady && $urandom_range(99, 0) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_inside_set <= in_set;
        s_smooth_iters <= iters;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_request(in_set, iters);
    endtask

    task automatic drain_pixels();
        s_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_setting(logic [15:0] typical, int unsigned spread);
        int unsigned roll;
        roll = $urandom_range(9, 0);
        case (roll)
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h7FFF;
            3: return 16'h8000;
            4: return 16'h0001;
            5, 6: return typical + 16'($urandom_range(spread, 0));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_iters(logic [15:0] max_iter);
        longint      span;
        int unsigned roll;
        span = longint'(max_iter) << 16;
        if (span == 0 || span > 32'h7FFF_FFFF) begin
            span = 32'h7FFF_FFFF;
        end
        roll = $urandom_range(99, 0);
        if (roll < 40) begin
            return 32'($urandom_range(32'(span), 0));
        end else if (roll < 60) begin
            return 32'($urandom_range(32'h00FF_FFFF, 0)) - 32'h0080_0000;
        end else if (roll < 85) begin
            return $urandom;
        end
        case ($urandom_range(5, 0))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'hFFFF_FFFF;
            3: return 32'h7FFF_FFFF;
            4: return 32'h8000_0000;
            default: return {16'($urandom), 16'h0000};
        endcase
    endfunction

    initial begin
        board = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: grey levels, black inside, clamping and sign.
        send_pixel(1'b1, 32'h7FFF_FFFF);
        send_pixel(1'b0, 32'h0000_0000);
        send_pixel(1'b0, 32'hFFFF_FFFF);
        send_pixel(1'b0, 32'h8000_0000);
        send_pixel(1'b0, 32'h7FFF_FFFF);
        send_pixel(1'b0, 32'h0100_0000);
        send_pixel(1'b0, 32'h0080_0000);
        drain_pixels();

        // A zero divisor turns every positive count full white.
        configure(etpc_pkg::MODE_GREY, 1'b1, 16'h0000, etpc_pkg::RST_COLOUR_MULTIPLIER,
                  etpc_pkg::RST_COLOUR_OFFSET);
        send_pixel(1'b1, 32'h0000_0000);
        send_pixel(1'b0, 32'h0000_0001);
        send_pixel(1'b0, 32'h0000_0000);
        drain_pixels();

        configure(etpc_pkg::MODE_GREY, 1'b1, 16'hFFFF, etpc_pkg::RST_COLOUR_MULTIPLIER,
                  etpc_pkg::RST_COLOUR_OFFSET);
        send_pixel(1'b0, 32'h7FFF_FFFF);
        drain_pixels();

        // Rainbow palette, including the wrap from the last entry to the first.
        configure(etpc_pkg::MODE_RAINBOW, 1'b1, etpc_pkg::RST_MAX_ITERATIONS,
                  etpc_pkg::RST_COLOUR_MULTIPLIER, etpc_pkg::RST_COLOUR_OFFSET);
        send_pixel(1'b0, 32'h0006_8000);
        send_pixel(1'b0, 32'hFFFF_FFFF);
        send_pixel(1'b0, 32'h8000_0000);
        send_pixel(1'b1, 32'h1234_5678);
        drain_pixels();

        configure(MODE_EARTH, 1'b0, etpc_pkg::RST_MAX_ITERATIONS, 16'hFFFF, 16'h8000);
        send_pixel(1'b0, 32'h7FFF_FFFF);
        send_pixel(1'b0, 32'h8000_0000);
        send_pixel(1'b0, 32'h0000_C000);
        send_pixel(1'b1, 32'h0000_0000);
        drain_pixels();

        configure(MODE_EARTH_ALIAS, 1'b0, 16'h0001, 16'h0000, 16'h7FFF);
        send_pixel(1'b0, 32'h1234_5678);
        send_pixel(1'b0, 32'hFFFF_FFFF);
        drain_pixels();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            steady = (phase == STEADY_PHASE);
            configure(2'($urandom_range(3, 0)), 1'($urandom),
                      pick_setting(16'd16, 1000), pick_setting(16'd1, 1023),
                      pick_setting(16'hFFEC, 40));
            repeat (PIXELS_PER_PHASE) begin
                send_pixel($urandom_range(99, 0) < INSIDE_PERCENT,
                           pick_iters(board.max_iterations));
            end
            drain_pixels();
        end
        steady = 1'b0;

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
